// ----- sv/pts_pkg.sv -----
package pts_pkg;

    // Field widths of the words on the ports
    localparam int COORD_W     = 16;
    localparam int TAG_W       = 12;
    localparam int MARGIN_W    = 8;
    localparam int MARGIN_FRAC = 4;
    localparam int DIST_W      = 12;
    localparam int DIST_FRAC   = 8;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd48;

    // Defaults for the top-level parameters
    localparam int COORD_INT_BITS_DEF  = 12;
    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int TAG_BITS_DEF        = 12;

    // Input word: one segment and one keypoint
    typedef struct packed {
        logic [COORD_W-1:0] seg_x1;
        logic [COORD_W-1:0] seg_y1;
        logic [COORD_W-1:0] seg_x2;
        logic [COORD_W-1:0] seg_y2;
        logic [COORD_W-1:0] pt_x;
        logic [COORD_W-1:0] pt_y;
        logic [TAG_W-1:0]   seg_tag;
        logic [TAG_W-1:0]   pt_tag;
    } pts_in_t;

    // Result word
    typedef struct packed {
        logic              on_segment;
        logic [DIST_W-1:0] perp_distance;
        logic [TAG_W-1:0]  seg_tag_out;
        logic [TAG_W-1:0]  pt_tag_out;
    } pts_out_t;

    // Side information that rides along the distance pipeline
    typedef struct packed {
        logic             pre;      // box, endpoint and non-zero length tests passed
        logic [TAG_W-1:0] seg_tag;
        logic [TAG_W-1:0] pt_tag;
    } pts_ctl_t;

    // Working fraction bits: at least the margin's
    function automatic int pts_wf(input int fb);
        return (fb > MARGIN_FRAC) ? fb : MARGIN_FRAC;
    endfunction

    // Coordinate bits kept from a port field
    function automatic int pts_cwe(input int ib, input int fb);
        return (ib + fb > COORD_W) ? COORD_W : ib + fb;
    endfunction

    // Aligned coordinate width
    function automatic int pts_aw(input int ib, input int fb);
        return pts_cwe(ib, fb) + pts_wf(fb) - fb;
    endfunction

    // Width of squared lengths
    function automatic int pts_sw(input int ib, input int fb);
        return 2 * pts_aw(ib, fb) + 1;
    endfunction

    // Left shift that brings |n|^2 to the scale of the distance search
    function automatic int pts_ex(input int fb);
        return 2 * DIST_FRAC - 2 * pts_wf(fb);
    endfunction

    // |n| is clamped at 2^H: anything larger beats every search candidate
    function automatic int pts_h(input int ib, input int fb);
        return (2 * DIST_W + 1 + pts_sw(ib, fb) - pts_ex(fb)) / 2;
    endfunction

    // Width of the scaled |n|^2
    function automatic int pts_rw(input int ib, input int fb);
        return 2 * pts_h(ib, fb) + pts_ex(fb) + 1;
    endfunction

    // Width of q^2 * s for any 12-bit q
    function automatic int pts_tw(input int ib, input int fb);
        return 2 * DIST_W + pts_sw(ib, fb);
    endfunction

    function automatic logic [TAG_W-1:0] pts_tag_mask(input int tb);
        return (tb >= TAG_W) ? {TAG_W{1'b1}} : TAG_W'((1 << tb) - 1);
    endfunction

endpackage

// ----- sv/point_to_segment_assignment_core.sv -----
// Point to segment assignment core.
// in_valid/in_ready carry one word per item: a segment, a keypoint and two
// tags. out_valid/out_ready return one result word per item, in order: the
// hit flag, the perpendicular distance (4.8 fixed point, zero on a miss) and
// the echoed tags. cfg_valid/cfg_ready write the 8-bit margin (4.4 pixels);
// cfg_ready is always high and the margin should only change while no item
// is in flight.
// Throughput is one word per cycle while the output is not stalled. The path
// runs through five geometry stages, twelve steps of the distance square root
// (one result bit each), and the output register.
// While out_valid is high and out_ready low, the whole pipeline holds and
// in_ready is low; nothing is dropped or repeated. Stalls on the input side
// simply leave bubbles that travel through.
// Reset empties the pipeline (all valid bits clear) and sets the margin to
// 3.0 pixels.
module point_to_segment_assignment_core
    import pts_pkg::*;
#(
    parameter int COORD_INT_BITS  = COORD_INT_BITS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int TAG_BITS        = TAG_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pts_in_t             in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pts_out_t            out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MARGIN_W-1:0] cfg_data
);

    localparam int SW = pts_sw(COORD_INT_BITS, COORD_FRAC_BITS);
    localparam int RW = pts_rw(COORD_INT_BITS, COORD_FRAC_BITS);
    localparam int TW = pts_tw(COORD_INT_BITS, COORD_FRAC_BITS);

    // Margin register
    logic [MARGIN_W-1:0] margin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            margin_reg <= MARGIN_RESET;
        else if (cfg_valid && cfg_ready)
            margin_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;

    // Pipeline moves whenever the output register can take a word
    logic     adv;
    logic     out_valid_reg;
    pts_out_t out_data_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Geometry front end
    logic          g_valid;
    pts_ctl_t      g_ctl;
    logic [SW-1:0] g_s;
    logic [RW-1:0] g_r;

    pts_geom #(
        .COORD_INT_BITS  (COORD_INT_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .TAG_BITS        (TAG_BITS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .margin    (margin_reg),
        .out_valid (g_valid),
        .out_ctl   (g_ctl),
        .out_s     (g_s),
        .out_r     (g_r)
    );

    // Distance search
    logic              rt_valid;
    pts_ctl_t          rt_ctl;
    logic [RW-1:0]     rt_r;
    logic [DIST_W-1:0] rt_q;
    logic [TW-1:0]     rt_q2s;

    pts_root #(
        .COORD_INT_BITS  (COORD_INT_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (g_valid),
        .in_ctl    (g_ctl),
        .in_s      (g_s),
        .in_r      (g_r),
        .out_valid (rt_valid),
        .out_ctl   (rt_ctl),
        .out_r     (rt_r),
        .out_q     (rt_q),
        .out_q2s   (rt_q2s)
    );

    // Distance test from the search result: q^2 s <= R < (q+1)^2 s,
    // so R <= M^2 s holds when q < M, or when q == M and the bound is exact
    logic [DIST_W-1:0] m_dist;
    logic              near;
    logic              hit;
    pts_out_t          out_data_next;

    assign m_dist = DIST_W'(margin_reg) << (DIST_FRAC - MARGIN_FRAC);
    assign near   = (rt_q < m_dist) || (rt_q == m_dist && RW'(rt_q2s) == rt_r);
    assign hit    = rt_ctl.pre && near;

    assign out_data_next.on_segment    = hit;
    assign out_data_next.perp_distance = hit ? rt_q : '0;
    assign out_data_next.seg_tag_out   = rt_ctl.seg_tag;
    assign out_data_next.pt_tag_out    = rt_ctl.pt_tag;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= rt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sv/pts_geom.sv -----
module pts_geom
    import pts_pkg::*;
#(
    parameter int COORD_INT_BITS  = COORD_INT_BITS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int TAG_BITS        = TAG_BITS_DEF,
    localparam int SW = pts_sw(COORD_INT_BITS, COORD_FRAC_BITS),
    localparam int RW = pts_rw(COORD_INT_BITS, COORD_FRAC_BITS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  pts_in_t             in_data,
    input  logic [MARGIN_W-1:0] margin,
    output logic                out_valid,
    output pts_ctl_t            out_ctl,
    output logic [SW-1:0]       out_s,
    output logic [RW-1:0]       out_r
);

    localparam int CWE = pts_cwe(COORD_INT_BITS, COORD_FRAC_BITS);
    localparam int WF  = pts_wf(COORD_FRAC_BITS);
    localparam int AW  = pts_aw(COORD_INT_BITS, COORD_FRAC_BITS);
    localparam int SH  = WF - COORD_FRAC_BITS;
    localparam int MW  = MARGIN_W + WF - MARGIN_FRAC;
    localparam int PW  = 2 * AW + 2;
    localparam int QW  = 2 * AW;
    localparam int NW  = 2 * AW + 1;
    localparam int EX  = pts_ex(COORD_FRAC_BITS);
    localparam int H   = pts_h(COORD_INT_BITS, COORD_FRAC_BITS);
    localparam logic [TAG_W-1:0] TAG_MASK = pts_tag_mask(TAG_BITS);

    // ------------------------------------------------------------------
    // Stage 1: align, differences, grown bounding box
    // ------------------------------------------------------------------
    logic [AW-1:0] x1, y1, x2, y2, px, py;
    logic [MW-1:0] m_al;
    logic [AW:0]   x1m, y1m, x2m, y2m, pxm, pym;
    logic [AW:0]   x1e, y1e, x2e, y2e, pxe, pye;

    assign x1   = AW'(in_data.seg_x1[CWE-1:0]) << SH;
    assign y1   = AW'(in_data.seg_y1[CWE-1:0]) << SH;
    assign x2   = AW'(in_data.seg_x2[CWE-1:0]) << SH;
    assign y2   = AW'(in_data.seg_y2[CWE-1:0]) << SH;
    assign px   = AW'(in_data.pt_x[CWE-1:0]) << SH;
    assign py   = AW'(in_data.pt_y[CWE-1:0]) << SH;
    assign m_al = MW'(margin) << (WF - MARGIN_FRAC);

    assign x1e = {1'b0, x1};
    assign y1e = {1'b0, y1};
    assign x2e = {1'b0, x2};
    assign y2e = {1'b0, y2};
    assign pxe = {1'b0, px};
    assign pye = {1'b0, py};
    assign x1m = x1e + (AW+1)'(m_al);
    assign y1m = y1e + (AW+1)'(m_al);
    assign x2m = x2e + (AW+1)'(m_al);
    assign y2m = y2e + (AW+1)'(m_al);
    assign pxm = pxe + (AW+1)'(m_al);
    assign pym = pye + (AW+1)'(m_al);

    logic              s1_box_next;
    logic signed [AW:0] s1_a_next, s1_b_next, s1_dx1_next, s1_dy1_next;
    logic signed [AW:0] s1_dx2_next, s1_dy2_next;

    // min - m <= p <= max + m, written without min/max muxes
    assign s1_box_next = (pxm >= x1e || pxm >= x2e) && (pxe <= x1m || pxe <= x2m) &&
                         (pym >= y1e || pym >= y2e) && (pye <= y1m || pye <= y2m);
    assign s1_a_next   = $signed(y2e) - $signed(y1e);
    assign s1_b_next   = $signed(x1e) - $signed(x2e);
    assign s1_dx1_next = $signed(pxe) - $signed(x1e);
    assign s1_dy1_next = $signed(pye) - $signed(y1e);
    assign s1_dx2_next = $signed(pxe) - $signed(x2e);
    assign s1_dy2_next = $signed(pye) - $signed(y2e);

    logic               s1_valid_reg;
    logic               s1_box_reg;
    logic signed [AW:0] s1_a_reg, s1_b_reg, s1_dx1_reg, s1_dy1_reg, s1_dx2_reg, s1_dy2_reg;
    logic [TAG_W-1:0]   s1_seg_tag_reg, s1_pt_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_box_reg     <= s1_box_next;
            s1_a_reg       <= s1_a_next;
            s1_b_reg       <= s1_b_next;
            s1_dx1_reg     <= s1_dx1_next;
            s1_dy1_reg     <= s1_dy1_next;
            s1_dx2_reg     <= s1_dx2_next;
            s1_dy2_reg     <= s1_dy2_next;
            s1_seg_tag_reg <= in_data.seg_tag & TAG_MASK;
            s1_pt_tag_reg  <= in_data.pt_tag & TAG_MASK;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] sq_a, sq_b, sq_dx1, sq_dy1, sq_dx2, sq_dy2;
    logic signed [PW-1:0] s2_pa_next, s2_pb_next;
    logic [2*MW-1:0]      s2_m2_next;

    assign sq_a       = PW'(s1_a_reg) * PW'(s1_a_reg);
    assign sq_b       = PW'(s1_b_reg) * PW'(s1_b_reg);
    assign sq_dx1     = PW'(s1_dx1_reg) * PW'(s1_dx1_reg);
    assign sq_dy1     = PW'(s1_dy1_reg) * PW'(s1_dy1_reg);
    assign sq_dx2     = PW'(s1_dx2_reg) * PW'(s1_dx2_reg);
    assign sq_dy2     = PW'(s1_dy2_reg) * PW'(s1_dy2_reg);
    assign s2_pa_next = PW'(s1_a_reg) * PW'(s1_dx1_reg);
    assign s2_pb_next = PW'(s1_b_reg) * PW'(s1_dy1_reg);
    assign s2_m2_next = (2*MW)'(m_al) * (2*MW)'(m_al);

    logic                 s2_valid_reg;
    logic                 s2_box_reg;
    logic [QW-1:0]        s2_sqa_reg, s2_sqb_reg;
    logic [QW-1:0]        s2_sqdx1_reg, s2_sqdy1_reg, s2_sqdx2_reg, s2_sqdy2_reg;
    logic signed [PW-1:0] s2_pa_reg, s2_pb_reg;
    logic [2*MW-1:0]      s2_m2_reg;
    logic [TAG_W-1:0]     s2_seg_tag_reg, s2_pt_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_box_reg     <= s1_box_reg;
            s2_sqa_reg     <= sq_a[QW-1:0];
            s2_sqb_reg     <= sq_b[QW-1:0];
            s2_sqdx1_reg   <= sq_dx1[QW-1:0];
            s2_sqdy1_reg   <= sq_dy1[QW-1:0];
            s2_sqdx2_reg   <= sq_dx2[QW-1:0];
            s2_sqdy2_reg   <= sq_dy2[QW-1:0];
            s2_pa_reg      <= s2_pa_next;
            s2_pb_reg      <= s2_pb_next;
            s2_m2_reg      <= s2_m2_next;
            s2_seg_tag_reg <= s1_seg_tag_reg;
            s2_pt_tag_reg  <= s1_pt_tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared length, cross term n, endpoint distances
    // ------------------------------------------------------------------
    logic [SW-1:0]        s3_s_next, s3_d1_next, s3_d2_next;
    logic signed [PW-1:0] s3_n_next;

    assign s3_s_next  = SW'(s2_sqa_reg) + SW'(s2_sqb_reg);
    assign s3_d1_next = SW'(s2_sqdx1_reg) + SW'(s2_sqdy1_reg);
    assign s3_d2_next = SW'(s2_sqdx2_reg) + SW'(s2_sqdy2_reg);
    assign s3_n_next  = s2_pa_reg + s2_pb_reg;

    logic                 s3_valid_reg;
    logic                 s3_box_reg;
    logic [SW-1:0]        s3_s_reg, s3_d1_reg, s3_d2_reg;
    logic signed [PW-1:0] s3_n_reg;
    logic [2*MW-1:0]      s3_m2_reg;
    logic [TAG_W-1:0]     s3_seg_tag_reg, s3_pt_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_box_reg     <= s2_box_reg;
            s3_s_reg       <= s3_s_next;
            s3_d1_reg      <= s3_d1_next;
            s3_d2_reg      <= s3_d2_next;
            s3_n_reg       <= s3_n_next;
            s3_m2_reg      <= s2_m2_reg;
            s3_seg_tag_reg <= s2_seg_tag_reg;
            s3_pt_tag_reg  <= s2_pt_tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: |n| with clamp, endpoint test
    // ------------------------------------------------------------------
    logic signed [PW-1:0] n_neg;
    logic [NW-1:0]        an;
    logic                 an_sat;
    logic [H:0]           s4_an_next;
    logic [SW:0]          d1_w, d2_w, m2_w, s_d1, s_d2;
    logic                 endp;
    logic                 s4_pre_next;

    assign n_neg      = -s3_n_reg;
    assign an         = s3_n_reg[PW-1] ? NW'(n_neg) : NW'(s3_n_reg);
    assign an_sat     = (an >> H) != '0;
    assign s4_an_next = an_sat ? ((H+1)'(1) << H) : (H+1)'(an);

    assign d1_w = (SW+1)'(s3_d1_reg);
    assign d2_w = (SW+1)'(s3_d2_reg);
    assign m2_w = (SW+1)'(s3_m2_reg);
    assign s_d1 = (SW+1)'(s3_s_reg) + d1_w;
    assign s_d2 = (SW+1)'(s3_s_reg) + d2_w;

    // near an endpoint, or projecting strictly inside the segment
    assign endp = (d1_w <= m2_w) || (d2_w <= m2_w) || (d1_w < s_d2 && d2_w < s_d1);
    assign s4_pre_next = s3_box_reg && (s3_s_reg != '0) && endp;

    logic             s4_valid_reg;
    logic             s4_pre_reg;
    logic [H:0]       s4_an_reg;
    logic [SW-1:0]    s4_s_reg;
    logic [TAG_W-1:0] s4_seg_tag_reg, s4_pt_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_pre_reg     <= s4_pre_next;
            s4_an_reg      <= s4_an_next;
            s4_s_reg       <= s3_s_reg;
            s4_seg_tag_reg <= s3_seg_tag_reg;
            s4_pt_tag_reg  <= s3_pt_tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: scaled |n|^2 for the distance search
    // ------------------------------------------------------------------
    logic [RW-1:0] an_sq;
    logic [RW-1:0] s5_r_next;

    assign an_sq     = RW'(s4_an_reg) * RW'(s4_an_reg);
    assign s5_r_next = an_sq << EX;

    logic             s5_valid_reg;
    logic             s5_pre_reg;
    logic [RW-1:0]    s5_r_reg;
    logic [SW-1:0]    s5_s_reg;
    logic [TAG_W-1:0] s5_seg_tag_reg, s5_pt_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_pre_reg     <= s4_pre_reg;
            s5_r_reg       <= s5_r_next;
            s5_s_reg       <= s4_s_reg;
            s5_seg_tag_reg <= s4_seg_tag_reg;
            s5_pt_tag_reg  <= s4_pt_tag_reg;
        end
    end

    // Valid bits of the five stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    assign out_valid       = s5_valid_reg;
    assign out_ctl.pre     = s5_pre_reg;
    assign out_ctl.seg_tag = s5_seg_tag_reg;
    assign out_ctl.pt_tag  = s5_pt_tag_reg;
    assign out_s           = s5_s_reg;
    assign out_r           = s5_r_reg;

endmodule

// ----- sv/pts_root_step.sv -----
module pts_root_step
    import pts_pkg::*;
#(
    parameter int COORD_INT_BITS  = COORD_INT_BITS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int BIT             = 0,
    localparam int SW  = pts_sw(COORD_INT_BITS, COORD_FRAC_BITS),
    localparam int RW  = pts_rw(COORD_INT_BITS, COORD_FRAC_BITS),
    localparam int TW  = pts_tw(COORD_INT_BITS, COORD_FRAC_BITS),
    localparam int QSW = DIST_W + SW
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  pts_ctl_t          in_ctl,
    input  logic [SW-1:0]     in_s,
    input  logic [RW-1:0]     in_r,
    input  logic [DIST_W-1:0] in_q,
    input  logic [TW-1:0]     in_q2s,
    input  logic [QSW-1:0]    in_qs,
    output logic              out_valid,
    output pts_ctl_t          out_ctl,
    output logic [SW-1:0]     out_s,
    output logic [RW-1:0]     out_r,
    output logic [DIST_W-1:0] out_q,
    output logic [TW-1:0]     out_q2s,
    output logic [QSW-1:0]    out_qs
);

    // (q + 2^b)^2 s = q^2 s + 2^(b+1) q s + 2^(2b) s
    logic [TW-1:0]     cand;
    logic              take;
    logic [DIST_W-1:0] q_next;
    logic [TW-1:0]     q2s_next;
    logic [QSW-1:0]    qs_next;

    assign cand     = in_q2s + (TW'(in_qs) << (BIT + 1)) + (TW'(in_s) << (2 * BIT));
    assign take     = RW'(cand) <= in_r;
    assign q_next   = take ? (in_q | (DIST_W'(1) << BIT)) : in_q;
    assign q2s_next = take ? cand : in_q2s;
    assign qs_next  = take ? (in_qs + (QSW'(in_s) << BIT)) : in_qs;

    logic              valid_reg;
    pts_ctl_t          ctl_reg;
    logic [SW-1:0]     s_reg;
    logic [RW-1:0]     r_reg;
    logic [DIST_W-1:0] q_reg;
    logic [TW-1:0]     q2s_reg;
    logic [QSW-1:0]    qs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= in_ctl;
            s_reg   <= in_s;
            r_reg   <= in_r;
            q_reg   <= q_next;
            q2s_reg <= q2s_next;
            qs_reg  <= qs_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_s     = s_reg;
    assign out_r     = r_reg;
    assign out_q     = q_reg;
    assign out_q2s   = q2s_reg;
    assign out_qs    = qs_reg;

endmodule

// ----- sv/pts_root.sv -----
module pts_root
    import pts_pkg::*;
#(
    parameter int COORD_INT_BITS  = COORD_INT_BITS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    localparam int SW = pts_sw(COORD_INT_BITS, COORD_FRAC_BITS),
    localparam int RW = pts_rw(COORD_INT_BITS, COORD_FRAC_BITS),
    localparam int TW = pts_tw(COORD_INT_BITS, COORD_FRAC_BITS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  pts_ctl_t          in_ctl,
    input  logic [SW-1:0]     in_s,
    input  logic [RW-1:0]     in_r,
    output logic              out_valid,
    output pts_ctl_t          out_ctl,
    output logic [RW-1:0]     out_r,
    output logic [DIST_W-1:0] out_q,
    output logic [TW-1:0]     out_q2s
);

    localparam int QSW = DIST_W + SW;

    // Index k holds what enters step k; step k settles bit DIST_W-1-k
    logic              st_valid [0:DIST_W];
    pts_ctl_t          st_ctl   [0:DIST_W];
    logic [RW-1:0]     st_r     [0:DIST_W];
    logic [DIST_W-1:0] st_q     [0:DIST_W];
    logic [TW-1:0]     st_q2s   [0:DIST_W];
    logic [SW-1:0]     st_s     [0:DIST_W];
    logic [QSW-1:0]    st_qs    [0:DIST_W];

    assign st_valid[0] = in_valid;
    assign st_ctl[0]   = in_ctl;
    assign st_r[0]     = in_r;
    assign st_s[0]     = in_s;
    assign st_q[0]     = '0;
    assign st_q2s[0]   = '0;
    assign st_qs[0]    = '0;

    // One compare-and-accumulate step per result bit, MSB first
    for (genvar k = 0; k < DIST_W; k++)
    begin : g_step
        pts_root_step #(
            .COORD_INT_BITS  (COORD_INT_BITS),
            .COORD_FRAC_BITS (COORD_FRAC_BITS),
            .BIT             (DIST_W - 1 - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (st_valid[k]),
            .in_ctl    (st_ctl[k]),
            .in_s      (st_s[k]),
            .in_r      (st_r[k]),
            .in_q      (st_q[k]),
            .in_q2s    (st_q2s[k]),
            .in_qs     (st_qs[k]),
            .out_valid (st_valid[k+1]),
            .out_ctl   (st_ctl[k+1]),
            .out_s     (st_s[k+1]),
            .out_r     (st_r[k+1]),
            .out_q     (st_q[k+1]),
            .out_q2s   (st_q2s[k+1]),
            .out_qs    (st_qs[k+1])
        );
    end

    assign out_valid = st_valid[DIST_W];
    assign out_ctl   = st_ctl[DIST_W];
    assign out_r     = st_r[DIST_W];
    assign out_q     = st_q[DIST_W];
    assign out_q2s   = st_q2s[DIST_W];

endmodule

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 8;
    localparam int PAIRS_A_PHASE = 160;
    localparam int SQUEEZE_AT    = 420;
    localparam int SQUEEZE_LEN   = 120;
    localparam int TAIL_CYCLES   = 30;

    // One row of the directed table: the input word, and the result typed in
    // by hand where it is plain to see (typed = 0 leaves it to the predictor)
    typedef struct packed {
        pts_in_t  word;
        logic     typed;
        pts_out_t want;
    } probe_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    pts_in_t             in_data;
    logic                out_valid;
    logic                out_ready;
    pts_out_t            out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [MARGIN_W-1:0] cfg_data;

    pts_out_t            due_assignments[$];
    logic [MARGIN_W-1:0] margin_now;
    int                  errors   = 0;
    int                  checked  = 0;
    int                  hits     = 0;
    int                  accepted = 0;
    int                  settings = 1;
    int                  cycles   = 0;
    bit                  calm         = 1'b0;
    bit                  squeeze_on   = 1'b0;
    bit                  squeeze_done = 1'b0;

    // Margin 3.0 px; coordinates are 1/16 px
    probe_t probes [19] = '{
        // zero-length segments at both ends of the range
        {{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd0},
            1'b1, {1'b0, 12'd0, 12'd0, 12'd0}},
        {{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
            12'd4095, 12'd4095}, 1'b1, {1'b0, 12'd0, 12'd4095, 12'd4095}},
        // full diagonal, point in the far corner
        {{16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd65535, 12'd4095, 12'd0},
            1'b1, {1'b0, 12'd0, 12'd4095, 12'd0}},
        // horizontal segment: on the line, 1 px off, exactly at margin, just over
        {{16'd0, 16'd0, 16'd160, 16'd0, 16'd80, 16'd0, 12'd1, 12'd2},
            1'b1, {1'b1, 12'd0, 12'd1, 12'd2}},
        {{16'd0, 16'd0, 16'd160, 16'd0, 16'd80, 16'd16, 12'd3, 12'd4},
            1'b1, {1'b1, 12'd256, 12'd3, 12'd4}},
        {{16'd0, 16'd0, 16'd160, 16'd0, 16'd80, 16'd48, 12'd5, 12'd6},
            1'b1, {1'b1, 12'd768, 12'd5, 12'd6}},
        {{16'd0, 16'd0, 16'd160, 16'd0, 16'd80, 16'd49, 12'd7, 12'd8},
            1'b1, {1'b0, 12'd0, 12'd7, 12'd8}},
        // beyond the first endpoint, inside its radius; then on the box edge and just past it
        {{16'd160, 16'd160, 16'd320, 16'd160, 16'd140, 16'd170, 12'd9, 12'd10},
            1'b1, {1'b1, 12'd160, 12'd9, 12'd10}},
        {{16'd160, 16'd160, 16'd320, 16'd160, 16'd112, 16'd160, 12'd11, 12'd12},
            1'b1, {1'b1, 12'd0, 12'd11, 12'd12}},
        {{16'd160, 16'd160, 16'd320, 16'd160, 16'd111, 16'd160, 12'd13, 12'd14},
            1'b1, {1'b0, 12'd0, 12'd13, 12'd14}},
        // a point sitting exactly on a zero-length segment still misses
        {{16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 12'd15, 12'd16},
            1'b1, {1'b0, 12'd0, 12'd15, 12'd16}},
        // full-height vertical segment on the right edge, point 2 px inside
        {{16'd65535, 16'd0, 16'd65535, 16'd65535, 16'd65503, 16'd30000,
            12'd2730, 12'd1365}, 1'b1, {1'b1, 12'd512, 12'd2730, 12'd1365}},
        // left to the predictor
        {{16'd0, 16'd0, 16'd800, 16'd800, 16'd400, 16'd420, 12'd17, 12'd18},
            1'b0, {1'b0, 12'd0, 12'd0, 12'd0}},
        {{16'd0, 16'd0, 16'd800, 16'd800, 16'd830, 16'd860, 12'd19, 12'd20},
            1'b0, {1'b0, 12'd0, 12'd0, 12'd0}},
        {{16'd160, 16'd0, 16'd0, 16'd0, 16'd80, 16'd16, 12'd21, 12'd22},
            1'b0, {1'b0, 12'd0, 12'd0, 12'd0}},
        {{16'd16, 16'd16, 16'd400, 16'd16, 16'd0, 16'd0, 12'd23, 12'd24},
            1'b0, {1'b0, 12'd0, 12'd0, 12'd0}},
        {{16'd2000, 16'd3000, 16'd2600, 16'd3900, 16'd2310, 16'd3450,
            12'd4095, 12'd4095}, 1'b0, {1'b0, 12'd0, 12'd0, 12'd0}},
        {{16'd1234, 16'd50000, 16'd1300, 16'd40000, 16'd1280, 16'd45000,
            12'd0, 12'd4095}, 1'b0, {1'b0, 12'd0, 12'd0, 12'd0}},
        {{16'd65535, 16'd65535, 16'd65519, 16'd65535, 16'd65527, 16'd65535,
            12'd100, 12'd200}, 1'b0, {1'b0, 12'd0, 12'd0, 12'd0}}
    };

    point_to_segment_assignment_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Expected assignment of one pair under a given margin, exact integers
    function automatic pts_out_t assignment_of(input pts_in_t w, input logic [7:0] mg);
        longint      x1, y1, x2, y2, px, py, m, a, b, s, n, d1, d2;
        longint      lox, hix, loy, hiy;
        logic [127:0] an, lhs, rhs, trial;
        logic [11:0] q, c;
        int          bit_i;
        pts_out_t    r;
        r.on_segment    = 1'b0;
        r.perp_distance = '0;
        r.seg_tag_out   = w.seg_tag;
        r.pt_tag_out    = w.pt_tag;
        x1 = {48'd0, w.seg_x1};
        y1 = {48'd0, w.seg_y1};
        x2 = {48'd0, w.seg_x2};
        y2 = {48'd0, w.seg_y2};
        px = {48'd0, w.pt_x};
        py = {48'd0, w.pt_y};
        m  = {56'd0, mg};
        lox = (x1 < x2) ? x1 : x2;
        hix = (x1 < x2) ? x2 : x1;
        loy = (y1 < y2) ? y1 : y2;
        hiy = (y1 < y2) ? y2 : y1;
        a = y2 - y1;
        b = x1 - x2;
        s = a * a + b * b;
        if (s != 0 && px >= lox - m && px <= hix + m && py >= loy - m && py <= hiy + m)
        begin
            n   = a * (px - x1) + b * (py - y1);
            an  = 128'((n < 0) ? -n : n);
            lhs = an * an;
            rhs = 128'(m * m) * 128'(s);
            if (lhs <= rhs)
            begin
                d1 = (x1 - px) * (x1 - px) + (y1 - py) * (y1 - py);
                d2 = (x2 - px) * (x2 - px) + (y2 - py) * (y2 - py);
                if (d1 <= m * m || d2 <= m * m || (d1 < s + d2 && d2 < s + d1))
                begin
                    r.on_segment = 1'b1;
                    // largest 4.8 q with (q px)^2 * s <= n^2, bit by bit
                    lhs = (an << 8) * (an << 8);
                    q   = '0;
                    for (bit_i = 11; bit_i >= 0; bit_i--)
                    begin
                        c     = q | (12'd1 << bit_i);
                        trial = 128'(c) * 128'(c) * 128'(256) * 128'(s);
                        if (trial <= lhs)
                            q = c;
                    end
                    r.perp_distance = q;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] fit16(input longint v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic logic [15:0] rim_coord();
        case ($urandom_range(0, 2))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random pair: mostly a point scattered round a segment or its endpoints,
    // some zero-length segments, pure noise and coordinates pinned to the rims
    function automatic pts_in_t random_pair(input logic [7:0] mg);
        pts_in_t w;
        longint  x1, y1, x2, y2, px, py, sp, t, r;
        int      kind;
        kind      = $urandom_range(0, 99);
        w.seg_tag = TAG_W'($urandom);
        w.pt_tag  = TAG_W'($urandom);
        x1 = longint'($urandom_range(0, 65535));
        y1 = longint'($urandom_range(0, 65535));
        if (kind < 80)
        begin
            case ($urandom_range(0, 3))
                0:       sp = 32;
                1:       sp = 512;
                2:       sp = 8192;
                default: sp = 65535;
            endcase
            x2 = longint'(fit16(x1 + longint'($urandom_range(0, 32'(2 * sp))) - sp));
            y2 = longint'(fit16(y1 + longint'($urandom_range(0, 32'(2 * sp))) - sp));
            if (kind >= 72)
            begin
                x2 = x1;
                y2 = y1;
            end
            if (kind < 60)
            begin
                t  = longint'($urandom_range(0, 1280)) - 128;
                px = x1 + (x2 - x1) * t / 1024;
                py = y1 + (y2 - y1) * t / 1024;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                px = x1;
                py = y1;
            end
            else
            begin
                px = x2;
                py = y2;
            end
            r  = 3 * longint'(mg) + 2;
            px = px + longint'($urandom_range(0, 32'(2 * r))) - r;
            py = py + longint'($urandom_range(0, 32'(2 * r))) - r;
            w.seg_x1 = fit16(x1);
            w.seg_y1 = fit16(y1);
            w.seg_x2 = fit16(x2);
            w.seg_y2 = fit16(y2);
            w.pt_x   = fit16(px);
            w.pt_y   = fit16(py);
        end
        else if (kind < 90)
        begin
            w.seg_x1 = 16'($urandom);
            w.seg_y1 = 16'($urandom);
            w.seg_x2 = 16'($urandom);
            w.seg_y2 = 16'($urandom);
            w.pt_x   = 16'($urandom);
            w.pt_y   = 16'($urandom);
        end
        else
        begin
            w.seg_x1 = rim_coord();
            w.seg_y1 = rim_coord();
            w.seg_x2 = rim_coord();
            w.seg_y2 = rim_coord();
            w.pt_x   = rim_coord();
            w.pt_y   = rim_coord();
        end
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Offer one word, hold it until taken, then maybe leave a gap
    task automatic offer(input pts_in_t w, input bit typed, input pts_out_t want);
        int       gap;
        pts_out_t due;
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        due = typed ? want : assignment_of(w, margin_now);
        due_assignments = {due_assignments, due};
        accepted++;
        if (!calm && !squeeze_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle();
        in_valid <= 1'b0;
        while (due_assignments.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_margin(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        margin_now = v;
        settings++;
    endtask

    // Sender: directed table, then random phases under changing margins
    initial
    begin : stimulus
        int          p;
        logic [7:0]  mg;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        margin_now = MARGIN_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
            offer(probes[i].word, probes[i].typed, probes[i].want);
        settle();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       mg = 8'd1;
                1:       mg = 8'd255;
                2:       mg = 8'd0;
                3:       mg = 8'd16;
                7:       mg = 8'd255;
                default: mg = 8'($urandom_range(2, 254));
            endcase
            // last phase runs flat out on both sides
            calm = (p == PHASES - 1);
            write_margin(mg);
            repeat (PAIRS_A_PHASE) offer(random_pair(margin_now), 1'b0, '0);
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d pairs checked under %0d margin settings, %0d assigned to their segment",
                 checked, settings, hits);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stall bursts, quiet stretches, and one long hold-off
    initial
    begin : sink
        int gap;
        int quiet;
        quiet     = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!squeeze_done && accepted >= SQUEEZE_AT)
            begin
                squeeze_on = 1'b1;
                out_ready <= 1'b0;
                repeat (SQUEEZE_LEN) @(posedge clk);
                squeeze_on   = 1'b0;
                squeeze_done = 1'b1;
            end
            else if (!calm && quiet == 0 && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                if (quiet > 0)
                    quiet--;
                else if ($urandom_range(0, 40) == 0)
                    quiet = $urandom_range(20, 80);
                @(posedge clk);
            end
        end
    end

    // Result check against the oldest outstanding expectation
    always @(posedge clk)
    begin : result_check
        pts_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_assignments.size() == 0)
            begin
                $error("result word with no pair outstanding");
                errors++;
            end
            else
            begin
                want = due_assignments.pop_front();
                check_field("on_segment", 32'(want.on_segment), 32'(out_data.on_segment));
                check_field("perp_distance", 32'(want.perp_distance),
                            32'(out_data.perp_distance));
                check_field("seg_tag_out", 32'(want.seg_tag_out), 32'(out_data.seg_tag_out));
                check_field("pt_tag_out", 32'(want.pt_tag_out), 32'(out_data.pt_tag_out));
                if (out_data.on_segment === 1'b1)
                    hits++;
                checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
